>>> rtl/ucb1_best_child_select_assert.svh
// Assertion macros for the UCB1 child selection block.
// Used by the checker module; needs clk_i and rst_ni in scope.
`ifndef UCB1_BEST_CHILD_SELECT_ASSERT_SVH
`define UCB1_BEST_CHILD_SELECT_ASSERT_SVH

// same-cycle implication
`define UCB1_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ucb1 check failed");

// next-cycle implication
`define UCB1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ucb1 check failed");

`endif

>>> rtl/ucb1_bcs_pkg.sv
// Shared constants and types for the UCB1 child selection block.
// No dependencies.
package ucb1_bcs_pkg;

  localparam int MAX_CHILDREN = 256;
  localparam int POS_LIMIT = (MAX_CHILDREN < 256) ? MAX_CHILDREN : 256;

  localparam logic [15:0] WEIGHT_RESET = 16'd5000;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam int IN_W = 80;
  localparam int OUT_W = 8;

  typedef struct packed {
    logic [23:0] parent_visits;
    logic [23:0] child_visits;
    logic [31:0] child_reward;
  } in_data_t;

endpackage

>>> rtl/ucb1_best_child_select.sv
// UCB1 best-child selection: scores one child per transaction, reports winner on the last.
// A child with zero visits, or one after such a child, is not scored; a parent count of 0 skips ln and sqrt.
// Takes a new child only once the last is done; divisions, ln and sqrt run bit-serially through one
// shared subtractor and one shared 27x21 multiplier under the sequencer.
// Result appears in the cycle after the last child's work ends and is held until taken.
// Reset (async, active low) clears the selection and sets exploration weight to 5000.
module ucb1_best_child_select (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [15:0]                    cfg_wdata_i,     // exploration_weight
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ucb1_bcs_pkg::IN_W-1:0]  s_axis_tdata,    // child_reward, child_visits,
                                                          // parent_visits
  input  logic                           s_axis_tlast,    // last_child
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ucb1_bcs_pkg::OUT_W-1:0] m_axis_tdata,    // best_index
  output logic                           m_axis_tuser     // found
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVX = 3'd1;
  localparam logic [2:0] ST_LNSQ = 3'd2;
  localparam logic [2:0] ST_LNMU = 3'd3;
  localparam logic [2:0] ST_DIVR = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_EXMU = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  ucb1_bcs_pkg::in_data_t in_d;
  assign in_d = ucb1_bcs_pkg::in_data_t'(s_axis_tdata);

  logic [2:0]  state_q, state_d;
  logic [15:0] weight_q;
  logic        neg_q, last_q;
  logic [23:0] visits_q, parent_q;
  logic [47:0] dq_q, dq_d;
  logic [29:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [16:0] y_q, y_d;
  logic [15:0] frac_q, frac_d;
  logic [4:0]  k_q, k_d;
  logic [26:0] root_q, root_d;
  logic [53:0] rad_q, rad_d;
  logic [47:0] exploit_q, exploit_d;
  logic [42:0] explore_q, explore_d;

  logic [47:0] best_q, best_d;
  logic [7:0]  bpos_q, bpos_d, pos_q, pos_d;
  logic        have_q, have_d, unv_q, unv_d;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  oidx_q, oidx_d;
  logic        ofound_q, ofound_d;

  // shared subtractor
  logic [29:0] sub_a, sub_b;
  logic [30:0] diff;
  logic        ge;
  // shared multiplier
  logic [26:0] mul_a;
  logic [20:0] mul_b;
  logic [47:0] prod;
  logic [17:0] sq;

  logic [4:0]  lead;
  logic [31:0] mag;
  logic [48:0] exploit_s, score;
  logic        accept, stall;

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[30];
  assign prod = {21'd0, mul_a} * {27'd0, mul_b};
  assign sq   = prod[33:16];

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (parent_q[i]) lead = 5'(i);
    end
  end

  assign mag       = in_d.child_reward[31] ? (32'd0 - in_d.child_reward) : in_d.child_reward;
  assign exploit_s = neg_q ? (49'd0 - {1'b0, exploit_q}) : {1'b0, exploit_q};
  assign score     = exploit_s + {6'd0, explore_q};

  assign accept = s_axis_tvalid && s_axis_tready;
  assign stall  = last_q && ovalid_q && !m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = oidx_q;
  assign m_axis_tuser  = ofound_q;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DIVX, ST_DIVR: begin
        sub_a = {5'd0, rem_q[23:0], dq_q[47]};
        sub_b = {6'd0, visits_q};
      end
      ST_SQRT: begin
        sub_a = {rem_q[27:0], rad_q[53:52]};
        sub_b = {1'b0, root_q, 2'b01};
      end
      ST_LNSQ: begin
        mul_a = {10'd0, y_q};
        mul_b = {4'd0, y_q};
      end
      ST_LNMU: begin
        mul_a = {6'd0, k_q, frac_q};
        mul_b = {5'd0, ucb1_bcs_pkg::LN2_Q16};
      end
      ST_EXMU: begin
        mul_a = root_q;
        mul_b = {5'd0, weight_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    y_d       = y_q;
    frac_d    = frac_q;
    k_d       = k_q;
    root_d    = root_q;
    rad_d     = rad_q;
    exploit_d = exploit_q;
    explore_d = explore_q;
    best_d    = best_q;
    bpos_d    = bpos_q;
    pos_d     = pos_q;
    have_d    = have_q;
    unv_d     = unv_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    oidx_d    = oidx_q;
    ofound_d  = ofound_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rem_d = '0;
          dq_d  = {mag, 16'd0};
          cnt_d = 6'd47;
          if (unv_q || in_d.child_visits == 24'd0) state_d = ST_FIN;
          else state_d = ST_DIVX;
        end
      end
      ST_DIVX, ST_DIVR: begin
        rem_d = ge ? {6'd0, diff[23:0]} : {6'd0, sub_a[23:0]};
        dq_d  = {dq_q[46:0], ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          if (state_q == ST_DIVX) begin
            exploit_d = {dq_q[46:0], ge};
            explore_d = '0;
            k_d       = lead;
            y_d       = 17'({parent_q, 16'd0} >> lead);
            frac_d    = '0;
            cnt_d     = 6'd15;
            state_d   = (parent_q == 24'd0) ? ST_FIN : ST_LNSQ;
          end else begin
            rad_d   = {dq_q[36:0], ge, 16'd0};
            rem_d   = '0;
            root_d  = '0;
            cnt_d   = 6'd26;
            state_d = ST_SQRT;
          end
        end
      end
      ST_LNSQ: begin
        y_d    = sq[17] ? sq[17:1] : sq[16:0];
        frac_d = {frac_q[14:0], sq[17]};
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == 6'd0) state_d = ST_LNMU;
      end
      ST_LNMU: begin
        // ratio numerator 2*ln<<16, aligned to the top of the divider
        dq_d    = {prod[36:16], 17'd0, 10'd0};
        rem_d   = '0;
        cnt_d   = 6'd37;
        state_d = ST_DIVR;
      end
      ST_SQRT: begin
        rem_d  = ge ? diff[29:0] : sub_a;
        root_d = {root_q[25:0], ge};
        rad_d  = {rad_q[51:0], 2'b00};
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == 6'd0) state_d = ST_EXMU;
      end
      ST_EXMU: begin
        explore_d = prod[42:0];
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (!stall) begin
          if (!unv_q) begin
            if (visits_q == 24'd0) begin
              unv_d  = 1'b1;
              have_d = 1'b1;
              bpos_d = pos_q;
            end else if ($signed(score) > $signed({1'b0, best_q})) begin
              best_d = score[47:0];
              bpos_d = pos_q;
              have_d = 1'b1;
            end
          end
          pos_d = (pos_q == 8'(ucb1_bcs_pkg::POS_LIMIT - 1)) ? 8'd0 : pos_q + 8'd1;
          if (last_q) begin
            ovalid_d = 1'b1;
            oidx_d   = have_d ? bpos_d : 8'd0;
            ofound_d = have_d;
            best_d   = '0;
            bpos_d   = '0;
            pos_d    = '0;
            have_d   = 1'b0;
            unv_d    = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      weight_q <= ucb1_bcs_pkg::WEIGHT_RESET;
      best_q   <= '0;
      bpos_q   <= '0;
      pos_q    <= '0;
      have_q   <= 1'b0;
      unv_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) weight_q <= cfg_wdata_i;
      best_q   <= best_d;
      bpos_q   <= bpos_d;
      pos_q    <= pos_d;
      have_q   <= have_d;
      unv_q    <= unv_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q    <= in_d.child_reward[31];
      visits_q <= in_d.child_visits;
      parent_q <= in_d.parent_visits;
      last_q   <= s_axis_tlast;
    end
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    y_q       <= y_d;
    frac_q    <= frac_d;
    k_q       <= k_d;
    root_q    <= root_d;
    rad_q     <= rad_d;
    exploit_q <= exploit_d;
    explore_q <= explore_d;
    oidx_q    <= oidx_d;
    ofound_q  <= ofound_d;
  end

endmodule

>>> rtl/ucb1_bcs_checker.sv
// Port-level checks for the UCB1 child selection block, bound to the top level.
// Depends on ucb1_bcs_pkg and ucb1_best_child_select_assert.svh.
`include "ucb1_best_child_select_assert.svh"

module ucb1_bcs_props (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ucb1_bcs_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  logic out_wait;
  assign out_wait = m_axis_tvalid && !m_axis_tready;

  // hold the result while the sink stalls
  `UCB1_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}))
  // no winner means index zero
  `UCB1_ASSERT_NOW(a_none_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  // sequencer is busy right after taking a child
  `UCB1_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind ucb1_best_child_select ucb1_bcs_props u_ucb1_bcs_props (.*);
